// File: design/msd_pkg.sv
// msd_pkg: shared types, register codes and reset constants for the
// matrix sensor debouncer. No dependencies.
`default_nettype none
package msd_pkg;

  localparam int ROWS_DEF    = 8;
  localparam int COLS_DEF    = 8;
  localparam int MAP_ENTRY_W = 3;
  localparam int MAP_W       = 8 * MAP_ENTRY_W;
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 16;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 8;

  // identity permutation: entry i holds i
  localparam logic [MAP_W-1:0] MAP_RST      = 24'd16434824;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_SWAP = 2'd0,
    REG_ROW_MAP   = 2'd1,
    REG_COL_MAP   = 2'd2,
    REG_DEBOUNCE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              stable;
    logic              last_raw;
    logic [TIME_W-1:0] change_time;
  } cell_state_t;

endpackage
`default_nettype wire

// File: design/msd_map.sv
// msd_map: physical to logical cell remap with optional axis swap and clamp.
// Depends on msd_pkg.
`default_nettype none
module msd_map #(
  parameter int ROWS   = 8,
  parameter int COLS   = 8,
  parameter int CELL_W = 6
) (
  input  wire logic [msd_pkg::MAP_ENTRY_W-1:0] raw_row,
  input  wire logic [msd_pkg::MAP_ENTRY_W-1:0] raw_col,
  input  wire logic                            axis_swap,
  input  wire logic [msd_pkg::MAP_W-1:0]       row_map,
  input  wire logic [msd_pkg::MAP_W-1:0]       col_map,
  output logic      [msd_pkg::MAP_ENTRY_W-1:0] logical_row,
  output logic      [msd_pkg::MAP_ENTRY_W-1:0] logical_col,
  output logic      [CELL_W-1:0]               cell_addr
);
  import msd_pkg::*;

  logic [MAP_ENTRY_W-1:0] row_idx, col_idx, row_ent, col_ent;

  always_comb begin
    row_idx = axis_swap ? raw_col : raw_row;
    col_idx = axis_swap ? raw_row : raw_col;
    row_ent = row_map[MAP_ENTRY_W*row_idx +: MAP_ENTRY_W];
    col_ent = col_map[MAP_ENTRY_W*col_idx +: MAP_ENTRY_W];
    // entries past the matrix edge pin to the last row/column
    logical_row = (int'(row_ent) >= ROWS) ? MAP_ENTRY_W'(ROWS - 1) : row_ent;
    logical_col = (int'(col_ent) >= COLS) ? MAP_ENTRY_W'(COLS - 1) : col_ent;
    cell_addr = CELL_W'(int'(logical_row) * COLS + int'(logical_col));
  end

endmodule
`default_nettype wire

// File: design/msd_cell_mem.sv
// msd_cell_mem: per-cell debounce state, one write and one registered read
// port, with per-entry valid flags so unwritten cells read as zero.
// Depends on msd_pkg.
`default_nettype none
module msd_cell_mem #(
  parameter int DEPTH  = 64,
  parameter int CELL_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [CELL_W-1:0]    rd_addr,
  output msd_pkg::cell_state_t      rd_data,
  input  wire logic                 wr_en,
  input  wire logic [CELL_W-1:0]    wr_addr,
  input  wire msd_pkg::cell_state_t wr_data
);
  import msd_pkg::*;

  cell_state_t        mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  cell_state_t        rd_q;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

// File: design/msd_update.sv
// msd_update: debounce decision for one cell, old state in, new state out.
// Depends on msd_pkg.
`default_nettype none
module msd_update (
  input  wire msd_pkg::cell_state_t           cur,
  input  wire logic                           reading,
  input  wire logic [msd_pkg::TIME_W-1:0]     now_ms,
  input  wire logic [msd_pkg::DEB_W-1:0]      debounce_ms,
  output msd_pkg::cell_state_t                nxt,
  output logic                                changed
);
  import msd_pkg::*;

  logic [TIME_W-1:0] elapsed;

  always_comb begin
    elapsed = now_ms - cur.change_time;  // wraps mod 2^32
    nxt     = cur;
    if (reading != cur.stable) begin
      if (reading != cur.last_raw) begin
        nxt.last_raw    = reading;
        nxt.change_time = now_ms;
      end else if (elapsed >= TIME_W'(debounce_ms)) begin
        nxt.stable = reading;
      end
    end else begin
      nxt.last_raw    = reading;
      nxt.change_time = now_ms;
    end
    changed = nxt.stable != cur.stable;
  end

endmodule
`default_nettype wire

// File: design/matrix_sensor_debounce.sv
// matrix_sensor_debounce: top level, cell remap, state memory pipeline,
// forwarding and output register. Depends on msd_pkg, msd_map,
// msd_cell_mem, msd_update.
//
//   port group   dir  contents
//   s_t*         in   sample: raw_row, raw_col, reading, now_ms
//   m_t*         out  result: logical_row, logical_col, present, changed
//   cfg_*        in   register writes, no read-back
//
// One sample per cycle sustained unless the output stalls. The state memory read
// runs as a sample enters the update stage; update and write-back as it leaves.
// A write-back is forwarded to the next sample when both hit the same cell.
// Synchronous reset clears all cell state at once through per-entry valid
// flags. An output stall holds the update stage and drops s_tready.
`default_nettype none
module matrix_sensor_debounce #(
  parameter int ROWS = msd_pkg::ROWS_DEF,
  parameter int COLS = msd_pkg::COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // raw_row[2:0], raw_col[5:3], reading[6], now_ms[38:7], zero pad
  input  wire logic [msd_pkg::S_DATA_W-1:0]   s_tdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // logical_row[2:0], logical_col[5:3], present[6], changed[7]
  output logic      [msd_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic                           cfg_wen,
  input  wire logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msd_pkg::CFG_W-1:0]      cfg_data
);
  import msd_pkg::*;

  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = $clog2(CELLS);

  // configuration
  logic             axis_swap;
  logic [MAP_W-1:0] row_map, col_map;
  logic [DEB_W-1:0] debounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_swap   <= 1'b0;
      row_map     <= MAP_RST;
      col_map     <= MAP_RST;
      debounce_ms <= DEBOUNCE_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_AXIS_SWAP: axis_swap   <= cfg_data[0];
        REG_ROW_MAP:   row_map     <= cfg_data[MAP_W-1:0];
        REG_COL_MAP:   col_map     <= cfg_data[MAP_W-1:0];
        REG_DEBOUNCE:  debounce_ms <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [MAP_ENTRY_W-1:0] in_row, in_col;
  logic                   in_reading;
  logic [TIME_W-1:0]      in_now;

  assign in_row     = s_tdata[2:0];
  assign in_col     = s_tdata[5:3];
  assign in_reading = s_tdata[6];
  assign in_now     = s_tdata[38:7];

  logic [MAP_ENTRY_W-1:0] map_lr, map_lc;
  logic [CELL_W-1:0]      map_cell;

  msd_map #(.ROWS(ROWS), .COLS(COLS), .CELL_W(CELL_W)) u_map (
    .raw_row    (in_row),
    .raw_col    (in_col),
    .axis_swap  (axis_swap),
    .row_map    (row_map),
    .col_map    (col_map),
    .logical_row(map_lr),
    .logical_col(map_lc),
    .cell_addr  (map_cell)
  );

  // update stage
  logic                   s1_valid;
  logic [MAP_ENTRY_W-1:0] s1_lr, s1_lc;
  logic [CELL_W-1:0]      s1_cell;
  logic                   s1_reading;
  logic [TIME_W-1:0]      s1_now;
  logic                   s1_adv, accept;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lr      <= map_lr;
      s1_lc      <= map_lc;
      s1_cell    <= map_cell;
      s1_reading <= in_reading;
      s1_now     <= in_now;
    end
  end

  cell_state_t mem_q, cur, nxt;
  logic        upd_changed;

  msd_cell_mem #(.DEPTH(CELLS), .CELL_W(CELL_W)) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(map_cell),
    .rd_data(mem_q),
    .wr_en  (s1_adv),
    .wr_addr(s1_cell),
    .wr_data(nxt)
  );

  // last write-back, for a read issued in the same cycle as that write
  logic              fw_valid;
  logic [CELL_W-1:0] fw_cell;
  cell_state_t       fw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (s1_adv) begin
      fw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fw_cell <= s1_cell;
      fw_data <= nxt;
    end
  end

  assign cur = (fw_valid && fw_cell == s1_cell) ? fw_data : mem_q;

  msd_update u_upd (
    .cur        (cur),
    .reading    (s1_reading),
    .now_ms     (s1_now),
    .debounce_ms(debounce_ms),
    .nxt        (nxt),
    .changed    (upd_changed)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {upd_changed, nxt.stable, s1_lc, s1_lr};
    end
  end

`ifndef SYNTHESIS
  // a change of stable value always lands on the sampled reading
  a_change_matches_reading: assert property (@(posedge clk) disable iff (rst)
    s1_adv && upd_changed |-> nxt.stable == s1_reading && cur.last_raw == s1_reading)
    else $error("stable value changed without a confirmed reading");

  // a held update stage keeps its sample
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_cell) && $stable(s1_now))
    else $error("update stage lost its sample while stalled");

  // every write-back is offered as a result on the next cycle
  a_result_follows_write: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> m_tvalid && m_tdata[6] == fw_data.stable)
    else $error("result does not match the written cell state");
`endif

endmodule
`default_nettype wire

// File: sim/matrix_sensor_debounce_test.sv
// matrix_sensor_debounce_test: self-checking bench for the matrix sensor debouncer.
// Drives scanned samples over the input stream, predicts each result from a local model
// of the cell store and compares every output transfer. Depends on msd_pkg and the RTL.
`default_nettype none
module matrix_sensor_debounce_test;
  timeunit 1ns;
  timeprecision 1ps;

  import msd_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int CELL_COUNT  = ROWS_DEF * COLS_DEF;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              reading;
    logic [2:0]        raw_col;
    logic [2:0]        raw_row;
  } sample_t;

  typedef struct packed {
    logic       changed;
    logic       present;
    logic [2:0] logical_col;
    logic [2:0] logical_row;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_wen = 1'b0;
  cfg_reg_t             cfg_index = REG_AXIS_SWAP;
  logic [CFG_W-1:0]     cfg_data = '0;

  // local copy of the block's registers and cell store
  logic                 swap_axes;
  logic [MAP_W-1:0]     row_perm;
  logic [MAP_W-1:0]     col_perm;
  logic [DEB_W-1:0]     hold_ms;
  logic                 cell_stable [CELL_COUNT];
  logic                 cell_last_raw [CELL_COUNT];
  logic [TIME_W-1:0]    cell_stamp [CELL_COUNT];

  cell_result_t         pending_results [$];
  int                   error_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_req = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  logic [TIME_W-1:0]    scan_ms = '0;
  cell_result_t         got_result;
  cell_result_t         want_result;

  matrix_sensor_debounce dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Remap the sample, run the per-cell debounce and return the expected result.
  // Map entries are 3 bits against an 8 by 8 matrix, so no clamping can occur.
  function automatic cell_result_t debounce_sample(sample_t smp);
    logic [2:0]        lr;
    logic [2:0]        lc;
    logic [5:0]        cell_no;
    logic              was;
    logic [TIME_W-1:0] elapsed;
    cell_result_t      res;
    lr = row_perm[3 * (swap_axes ? smp.raw_col : smp.raw_row) +: 3];
    lc = col_perm[3 * (swap_axes ? smp.raw_row : smp.raw_col) +: 3];
    cell_no = {lr, lc};
    was = cell_stable[cell_no];
    elapsed = smp.now_ms - cell_stamp[cell_no];
    if (smp.reading != was) begin
      if (smp.reading != cell_last_raw[cell_no]) begin
        cell_last_raw[cell_no] = smp.reading;
        cell_stamp[cell_no] = smp.now_ms;
      end else if (elapsed >= {16'b0, hold_ms}) begin
        cell_stable[cell_no] = smp.reading;
      end
    end else begin
      cell_last_raw[cell_no] = smp.reading;
      cell_stamp[cell_no] = smp.now_ms;
    end
    res.logical_row = lr;
    res.logical_col = lc;
    res.present = cell_stable[cell_no];
    res.changed = (cell_stable[cell_no] != was);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // result side: checks each transfer, then picks the next tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_result = m_tdata;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, m_tdata);
        end else begin
          want_result = pending_results.pop_front();
          check_field("logical_row", 32'(want_result.logical_row),
                      32'(got_result.logical_row));
          check_field("logical_col", 32'(want_result.logical_col),
                      32'(got_result.logical_col));
          check_field("present", 32'(want_result.present), 32'(got_result.present));
          check_field("changed", 32'(want_result.changed), 32'(got_result.changed));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offers one sample and returns at the edge of its transfer; tvalid is left high
  // so back-to-back samples need no second assignment in one step.
  task automatic send_sample(logic [2:0] row, logic [2:0] col, logic rd,
                             logic [TIME_W-1:0] now);
    int      gap;
    sample_t smp;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.raw_row = row;
    smp.raw_col = col;
    smp.reading = rd;
    smp.now_ms = now;
    s_tdata <= {1'b0, smp};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(debounce_sample(smp));
  endtask

  // must be called in the step of the last transfer
  task automatic drain_results();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic swap, logic [MAP_W-1:0] rmap, logic [MAP_W-1:0] cmap,
                           logic [DEB_W-1:0] deb);
    drain_results();
    cfg_wen <= 1'b1;
    cfg_index <= REG_AXIS_SWAP;
    cfg_data <= {23'b0, swap};
    @(posedge clk);
    cfg_index <= REG_ROW_MAP;
    cfg_data <= rmap;
    @(posedge clk);
    cfg_index <= REG_COL_MAP;
    cfg_data <= cmap;
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= {8'b0, deb};
    @(posedge clk);
    cfg_wen <= 1'b0;
    swap_axes = swap;
    row_perm = rmap;
    col_perm = cmap;
    hold_ms = deb;
  endtask

  // Mostly runs of samples on one cell with time moving on by up to half the hold time
  // plus 2 ms, some with a bounce; the rest single samples at random times.
  task automatic send_random_samples(int count);
    int          sent;
    int          burst;
    int unsigned step_max;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        rd;
    sent = 0;
    step_max = hold_ms / 2 + 2;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        row = 3'($urandom());
        col = 3'($urandom());
        rd = 1'($urandom());
        burst = $urandom_range(2, 5);
        repeat (burst) begin
          scan_ms += $urandom_range(0, step_max);
          send_sample(row, col, ($urandom_range(0, 4) == 0) ? !rd : rd, scan_ms);
          sent++;
        end
      end else begin
        send_sample(3'($urandom()), 3'($urandom()), 1'($urandom()), $urandom());
        sent++;
      end
    end
  endtask

  // reset values: identity maps, 100 ms hold
  task automatic test_default_hold();
    send_sample(3'd0, 3'd0, 1'b1, 32'd0);
    send_sample(3'd0, 3'd0, 1'b1, 32'd99);
    send_sample(3'd0, 3'd0, 1'b1, 32'd100);
    send_sample(3'd0, 3'd0, 1'b0, 32'd150);
    send_sample(3'd0, 3'd0, 1'b1, 32'd160);
    // hold time measured across the 32-bit wrap
    send_sample(3'd7, 3'd7, 1'b1, 32'hFFFF_FFFF);
    send_sample(3'd7, 3'd7, 1'b1, 32'd99);
    send_sample(3'd7, 3'd0, 1'b0, 32'd5);
    send_sample(3'd0, 3'd7, 1'b1, 32'd7);
    drain_results();
  endtask

  // zero hold: first differing sample only records, the second takes it
  task automatic test_zero_hold();
    configure(1'b0, MAP_RST, MAP_RST, 16'd0);
    send_sample(3'd3, 3'd4, 1'b1, 32'd1000);
    send_sample(3'd3, 3'd4, 1'b1, 32'd1000);
    drain_results();
  endtask

  task automatic test_max_hold_swapped();
    configure(1'b1, 24'o01234567, 24'o01234567, 16'hFFFF);
    send_sample(3'd2, 3'd5, 1'b1, 32'hFFFF_FFF0);
    send_sample(3'd2, 3'd5, 1'b1, 32'h0000_FFEE);
    send_sample(3'd2, 3'd5, 1'b1, 32'h0000_FFEF);
    drain_results();
  endtask

  // all rows map to 0 and all columns to 7, so every position shares one cell
  task automatic test_shared_cell();
    configure(1'b0, 24'h000000, 24'hFFFFFF, 16'd0);
    send_sample(3'd1, 3'd2, 1'b1, 32'd500);
    send_sample(3'd6, 3'd3, 1'b1, 32'd500);
    send_sample(3'd4, 3'd4, 1'b0, 32'd600);
    drain_results();
  endtask

  task automatic test_random_phase(int send_pct, int recv_pct, int count, logic swap,
                                   logic [MAP_W-1:0] rmap, logic [MAP_W-1:0] cmap,
                                   logic [DEB_W-1:0] deb, logic [TIME_W-1:0] start_ms);
    configure(swap, rmap, cmap, deb);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    scan_ms = start_ms;
    send_random_samples(count);
    drain_results();
  endtask

  // long output hold-off with the input kept busy, so the block backs up
  task automatic test_output_holdoff();
    configure(1'b0, MAP_RST, MAP_RST, 16'd20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    send_random_samples(60);
    drain_results();
  endtask

  initial begin
    int i;
    for (i = 0; i < CELL_COUNT; i++) begin
      cell_stable[i] = 1'b0;
      cell_last_raw[i] = 1'b0;
      cell_stamp[i] = '0;
    end
    swap_axes = 1'b0;
    row_perm = MAP_RST;
    col_perm = MAP_RST;
    hold_ms = DEBOUNCE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_hold();
    test_zero_hold();
    test_max_hold_swapped();
    test_shared_cell();
    test_random_phase(0, 0, 440, 1'b0, MAP_RST, MAP_RST, DEBOUNCE_RST, $urandom());
    test_random_phase(49, 0, 440, 1'b1, 24'($urandom()), 24'($urandom()),
                      16'($urandom_range(1, 300)), $urandom());
    test_random_phase(0, 49, 440, 1'b0, 24'($urandom()), MAP_RST, 16'hFFFF,
                      32'hFFFE_0000);
    test_random_phase(35, 35, 440, 1'($urandom()), 24'o01234567, 24'($urandom()),
                      16'd0, $urandom());
    test_output_holdoff();

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/msd_pkg.sv
design/msd_map.sv
design/msd_cell_mem.sv
design/msd_update.sv
design/matrix_sensor_debounce.sv
sim/matrix_sensor_debounce_test.sv
